[design/nps_pkg.sv]
// Shared types and constants for the non-preemptive priority scheduler.
`timescale 1ns / 1ps

package nps_pkg;

    localparam int DEFAULT_READY_DEPTH = 16;

    localparam int ID_W    = 16;
    localparam int TIME_W  = 32;
    localparam int LEN_W   = 16;
    localparam int PRIO_W  = 8;
    localparam int STAMP_W = 16;

    // order_descending register codes
    localparam logic ORDER_ASC  = 1'b0;
    localparam logic ORDER_DESC = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DISP,
        S_INSERT,
        S_DRAIN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic clamp;
        logic insert;
        logic dispatch;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic lt_arr;
        logic any_valid;
        logic scan_done;
        logic emit_ok;
        logic is_last;
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]    job;
        logic [TIME_W-1:0]  arrival;
        logic [LEN_W-1:0]   length;
        logic [PRIO_W-1:0]  prio;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

endpackage

[design/nonpreemptive_priority_scheduler_top.sv]
// Sequence: a job with no dispatch passes through check, insert, drain and flush before
// the next input transfer is taken. Each dispatch adds a check, a scan of all READY_DEPTH
// entries through the registered table read, and the dispatch; the insert, dispatch and
// flush steps wait while the result hold and output stage are full. One job is in work at
// a time. Reset (synchronous, active low) clears the clock, the valid bits and the handshakes.
// Top level of the non-preemptive priority scheduler.
`timescale 1ns / 1ps

module nonpreemptive_priority_scheduler_top #(
    parameter int READY_DEPTH = nps_pkg::DEFAULT_READY_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [nps_pkg::ID_W-1:0]      i_job_id,
    input  logic [nps_pkg::TIME_W-1:0]    i_arrival_time,
    input  logic [nps_pkg::LEN_W-1:0]     i_run_length,
    input  logic [nps_pkg::PRIO_W-1:0]    i_job_priority,
    input  logic                          i_is_final_job,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [nps_pkg::ID_W-1:0]      o_sched_id,
    output logic [nps_pkg::TIME_W-1:0]    o_start_time,
    output logic [nps_pkg::TIME_W-1:0]    o_end_time,
    output logic [nps_pkg::TIME_W-1:0]    o_wait_time,
    output logic [nps_pkg::TIME_W-1:0]    o_idle_gap,
    output logic                          o_dropped,
    output logic                          o_run_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_order_descending
);

    nps_pkg::t_cmd    w_cmd;
    nps_pkg::t_status w_status;

    // the order register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

    nps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    nps_dp #(
        .READY_DEPTH (READY_DEPTH)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (w_cmd),
        .o_status               (w_status),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_order_descending (i_cfg_order_descending),
        .i_job_id               (i_job_id),
        .i_arrival_time         (i_arrival_time),
        .i_run_length           (i_run_length),
        .i_job_priority         (i_job_priority),
        .i_is_final_job         (i_is_final_job),
        .i_out_stall            (i_out_stall),
        .o_out_valid            (o_out_valid),
        .o_sched_id             (o_sched_id),
        .o_start_time           (o_start_time),
        .o_end_time             (o_end_time),
        .o_wait_time            (o_wait_time),
        .o_idle_gap             (o_idle_gap),
        .o_dropped              (o_dropped),
        .o_run_last             (o_run_last)
    );

endmodule

[design/nps_ctrl.sv]
// Controller state machine: sequences search, dispatch, insert, drain and flush per job.
`timescale 1ns / 1ps

module nps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  nps_pkg::t_status i_status,
    output nps_pkg::t_cmd    o_cmd
);

    nps_pkg::t_state r_state, n_state;
    logic            r_drain, n_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nps_pkg::S_IDLE;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_drain    = r_drain;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            nps_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_drain    = 1'b0;
                    n_state    = nps_pkg::S_CHECK;
                end
            end
            nps_pkg::S_CHECK: begin
                if (i_status.lt_arr && i_status.any_valid) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = nps_pkg::S_SCAN;
                end else begin
                    // table empty or clock caught up: jump clock to arrival
                    o_cmd.clamp = 1'b1;
                    n_state     = nps_pkg::S_INSERT;
                end
            end
            nps_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) begin
                    n_state = nps_pkg::S_DISP;
                end
            end
            nps_pkg::S_DISP: begin
                if (i_status.emit_ok) begin
                    o_cmd.dispatch = 1'b1;
                    n_state        = r_drain ? nps_pkg::S_DRAIN : nps_pkg::S_CHECK;
                end
            end
            nps_pkg::S_INSERT: begin
                if (i_status.emit_ok) begin
                    o_cmd.insert = 1'b1;
                    n_state      = nps_pkg::S_DRAIN;
                end
            end
            nps_pkg::S_DRAIN: begin
                if (i_status.is_last && i_status.any_valid) begin
                    o_cmd.scan_start = 1'b1;
                    n_drain          = 1'b1;
                    n_state          = nps_pkg::S_SCAN;
                end else begin
                    n_state = nps_pkg::S_FLUSH;
                end
            end
            nps_pkg::S_FLUSH: begin
                if (i_status.emit_ok) begin
                    o_cmd.flush = 1'b1;
                    n_state     = nps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nps_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[design/nps_dp.sv]
// Datapath: ready table, CPU clock, priority scan, result hold and output registers.
`timescale 1ns / 1ps

module nps_dp #(
    parameter int READY_DEPTH = nps_pkg::DEFAULT_READY_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nps_pkg::t_cmd                 i_cmd,
    output nps_pkg::t_status              o_status,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_order_descending,
    input  logic [nps_pkg::ID_W-1:0]      i_job_id,
    input  logic [nps_pkg::TIME_W-1:0]    i_arrival_time,
    input  logic [nps_pkg::LEN_W-1:0]     i_run_length,
    input  logic [nps_pkg::PRIO_W-1:0]    i_job_priority,
    input  logic                          i_is_final_job,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [nps_pkg::ID_W-1:0]      o_sched_id,
    output logic [nps_pkg::TIME_W-1:0]    o_start_time,
    output logic [nps_pkg::TIME_W-1:0]    o_end_time,
    output logic [nps_pkg::TIME_W-1:0]    o_wait_time,
    output logic [nps_pkg::TIME_W-1:0]    o_idle_gap,
    output logic                          o_dropped,
    output logic                          o_run_last
);

    localparam int AW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
    localparam int CW = $clog2(READY_DEPTH + 1);
    localparam int TW = nps_pkg::TIME_W;

    // configuration
    logic r_order_desc;

    // current job
    logic [nps_pkg::ID_W-1:0]   r_id;
    logic [TW-1:0]              r_arr;
    logic [nps_pkg::LEN_W-1:0]  r_len;
    logic [nps_pkg::PRIO_W-1:0] r_prio;
    logic                       r_last;

    // timeline
    logic [TW-1:0]               r_clock;
    logic [TW-1:0]               r_idle;
    logic                        r_started;
    logic [nps_pkg::STAMP_W-1:0] r_ins_cnt;

    // ready table
    nps_pkg::t_entry          r_mem [READY_DEPTH];
    logic [READY_DEPTH-1:0]   r_valid;
    nps_pkg::t_entry          r_rd;

    // scan
    logic [CW-1:0]               r_scan_cnt;
    logic                        r_pipe_v;
    logic [AW-1:0]               r_pipe_idx;
    logic                        r_best_found;
    logic [AW-1:0]               r_best_idx;
    logic [nps_pkg::PRIO_W-1:0]  r_best_prio;
    logic [nps_pkg::STAMP_W-1:0] r_best_age;
    logic [nps_pkg::ID_W-1:0]    r_best_job;
    logic [TW-1:0]               r_best_arr;
    logic [nps_pkg::LEN_W-1:0]   r_best_len;

    // result hold and output stage
    logic                       r_hold_v;
    logic [nps_pkg::ID_W-1:0]   r_hold_id;
    logic [TW-1:0]              r_hold_start;
    logic [TW-1:0]              r_hold_end;
    logic [TW-1:0]              r_hold_wait;
    logic [TW-1:0]              r_hold_gap;
    logic                       r_hold_drop;
    logic                       r_out_v;

    logic                        w_issue;
    logic                        w_cand_live;
    logic [nps_pkg::STAMP_W-1:0] w_cand_age;
    logic                        w_better;
    logic                        w_found;
    logic [AW-1:0]               w_slot;
    logic [TW-1:0]               w_end;
    logic                        w_out_free;
    logic                        w_emit;
    logic                        w_move;

    assign w_issue     = i_cmd.scan_step && (r_scan_cnt < CW'(READY_DEPTH));
    assign w_cand_live = r_pipe_v && r_valid[r_pipe_idx];
    assign w_cand_age  = r_ins_cnt - r_rd.stamp;

    always_comb begin
        if (!r_best_found) begin
            w_better = 1'b1;
        end else if (r_rd.prio != r_best_prio) begin
            w_better = (r_order_desc == nps_pkg::ORDER_DESC) ? (r_rd.prio > r_best_prio)
                                                             : (r_rd.prio < r_best_prio);
        end else begin
            // equal priority: older entry wins
            w_better = w_cand_age > r_best_age;
        end
    end

    // lowest free entry
    always_comb begin
        w_found = 1'b0;
        w_slot  = '0;
        for (int i = READY_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_found = 1'b1;
                w_slot  = AW'(i);
            end
        end
    end

    assign w_end      = r_clock + TW'(r_best_len);
    assign w_out_free = !r_out_v || !i_out_stall;
    assign w_emit     = i_cmd.dispatch || (i_cmd.insert && !w_found);
    assign w_move     = r_hold_v && w_out_free && (w_emit || i_cmd.flush);

    assign o_status.lt_arr    = r_clock < r_arr;
    assign o_status.any_valid = |r_valid;
    assign o_status.scan_done = (r_scan_cnt == CW'(READY_DEPTH)) && !r_pipe_v;
    assign o_status.emit_ok   = !r_hold_v || w_out_free;
    assign o_status.is_last   = r_last;

    // table storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && w_found) begin
            r_mem[w_slot] <= '{job: r_id, arrival: r_arr, length: r_len,
                               prio: r_prio, stamp: r_ins_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd <= r_mem[r_scan_cnt[AW-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_desc <= nps_pkg::ORDER_ASC;
            r_clock      <= '0;
            r_idle       <= '0;
            r_started    <= 1'b0;
            r_ins_cnt    <= '0;
            r_valid      <= '0;
            r_scan_cnt   <= '0;
            r_pipe_v     <= 1'b0;
            r_best_found <= 1'b0;
            r_hold_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_order_desc <= i_cfg_order_descending;
            end
            if (i_cmd.load && !r_started) begin
                // first job starts the clock with no idle gap
                r_clock   <= i_arrival_time;
                r_idle    <= i_arrival_time;
                r_started <= 1'b1;
            end
            if (i_cmd.clamp && (r_clock < r_arr)) begin
                r_clock <= r_arr;
            end
            if (i_cmd.dispatch) begin
                r_clock             <= w_end;
                r_idle              <= w_end;
                r_valid[r_best_idx] <= 1'b0;
            end
            if (i_cmd.insert && w_found) begin
                r_valid[w_slot] <= 1'b1;
                r_ins_cnt       <= r_ins_cnt + 1'b1;
            end

            if (i_cmd.scan_start) begin
                r_scan_cnt   <= '0;
                r_pipe_v     <= 1'b0;
                r_best_found <= 1'b0;
            end else begin
                if (w_issue) begin
                    r_scan_cnt <= r_scan_cnt + 1'b1;
                end
                r_pipe_v <= w_issue;
                if (w_cand_live && w_better) begin
                    r_best_found <= 1'b1;
                end
            end

            if (w_emit) begin
                r_hold_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_hold_v <= 1'b0;
            end

            if (w_move) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id   <= i_job_id;
            r_arr  <= i_arrival_time;
            r_len  <= i_run_length;
            r_prio <= i_job_priority;
            r_last <= i_is_final_job;
        end
        if (w_issue) begin
            r_pipe_idx <= r_scan_cnt[AW-1:0];
        end
        if (w_cand_live && w_better && !i_cmd.scan_start) begin
            r_best_idx  <= r_pipe_idx;
            r_best_prio <= r_rd.prio;
            r_best_age  <= w_cand_age;
            r_best_job  <= r_rd.job;
            r_best_arr  <= r_rd.arrival;
            r_best_len  <= r_rd.length;
        end
        if (i_cmd.dispatch) begin
            r_hold_id    <= r_best_job;
            r_hold_start <= r_clock;
            r_hold_end   <= w_end;
            r_hold_wait  <= r_clock - r_best_arr;
            r_hold_gap   <= r_clock - r_idle;
            r_hold_drop  <= 1'b0;
        end else if (i_cmd.insert && !w_found) begin
            r_hold_id    <= r_id;
            r_hold_start <= '0;
            r_hold_end   <= '0;
            r_hold_wait  <= '0;
            r_hold_gap   <= '0;
            r_hold_drop  <= 1'b1;
        end
        if (w_move) begin
            o_sched_id   <= r_hold_id;
            o_start_time <= r_hold_start;
            o_end_time   <= r_hold_end;
            o_wait_time  <= r_hold_wait;
            o_idle_gap   <= r_hold_gap;
            o_dropped    <= r_hold_drop;
            o_run_last   <= i_cmd.flush;
        end
    end

    assign o_out_valid = r_out_v;

    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_hold_v) |-> w_out_free)
        else $error("result produced while hold and output stage are full");

    a_dispatch_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dispatch |=> !r_valid[$past(r_best_idx)])
        else $error("dispatched entry still valid");

    a_scan_finds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_step && o_status.scan_done && (|r_valid)) |-> r_best_found)
        else $error("scan over a non-empty table found no entry");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> !r_hold_v)
        else $error("hold register still full after flush");

endmodule

[tb/nps_tb_pkg.sv]
// Dispatch predictor and result checker for the priority scheduler testbench.
`timescale 1ns / 1ps

package nps_tb_pkg;

    localparam int DEFAULT_READY_DEPTH = nps_pkg::DEFAULT_READY_DEPTH;
    localparam int ID_W                = nps_pkg::ID_W;
    localparam int TIME_W              = nps_pkg::TIME_W;
    localparam int LEN_W               = nps_pkg::LEN_W;
    localparam int PRIO_W              = nps_pkg::PRIO_W;
    localparam int STAMP_W             = nps_pkg::STAMP_W;

    typedef struct packed {
        bit [ID_W-1:0]   sched_id;
        bit [TIME_W-1:0] start_time;
        bit [TIME_W-1:0] end_time;
        bit [TIME_W-1:0] wait_time;
        bit [TIME_W-1:0] idle_gap;
        bit              dropped;
        bit              run_last;
    } t_dispatch;

    class dispatch_tracker;

        bit                order_desc;
        bit [TIME_W-1:0]   cpu_clock;
        bit [TIME_W-1:0]   idle_since;
        bit                clock_started;
        bit                occupied [DEFAULT_READY_DEPTH];
        nps_pkg::t_entry   slots [DEFAULT_READY_DEPTH];
        bit [STAMP_W-1:0]  insert_count;
        t_dispatch         pending [$];
        t_dispatch         step_out [$];
        int                mismatches;

        function new();
            order_desc    = nps_pkg::ORDER_ASC;
            cpu_clock     = '0;
            idle_since    = '0;
            clock_started = 1'b0;
            insert_count  = '0;
            mismatches    = 0;
            foreach (occupied[i]) occupied[i] = 1'b0;
        endfunction

        // Best priority wins; on a tie the oldest stamp relative to insert_count.
        function int pick_slot();
            int best;
            bit better;
            bit [STAMP_W-1:0] age_i;
            bit [STAMP_W-1:0] age_b;
            best = -1;
            for (int i = 0; i < DEFAULT_READY_DEPTH; i++) begin
                if (!occupied[i]) continue;
                if (best < 0) begin
                    best = i;
                    continue;
                end
                if (slots[i].prio != slots[best].prio) begin
                    better = (order_desc == nps_pkg::ORDER_DESC)
                           ? (slots[i].prio > slots[best].prio)
                           : (slots[i].prio < slots[best].prio);
                end else begin
                    age_i  = insert_count - slots[i].stamp;
                    age_b  = insert_count - slots[best].stamp;
                    better = age_i > age_b;
                end
                if (better) best = i;
            end
            return best;
        endfunction

        function bit dispatch_next();
            int b;
            t_dispatch d;
            b = pick_slot();
            if (b < 0) return 1'b0;
            d            = '0;
            d.sched_id   = slots[b].job;
            d.start_time = cpu_clock;
            d.end_time   = cpu_clock + TIME_W'(slots[b].length);
            d.wait_time  = cpu_clock - slots[b].arrival;
            d.idle_gap   = cpu_clock - idle_since;
            step_out.push_back(d);
            occupied[b] = 1'b0;
            cpu_clock   = d.end_time;
            idle_since  = d.end_time;
            return 1'b1;
        endfunction

        function void note_job(bit [ID_W-1:0] id, bit [TIME_W-1:0] arr,
                               bit [LEN_W-1:0] len, bit [PRIO_W-1:0] prio, bit last);
            int free_slot;
            t_dispatch d;
            step_out.delete();
            if (!clock_started) begin
                cpu_clock     = arr;
                idle_since    = arr;
                clock_started = 1'b1;
            end
            while (cpu_clock < arr)
                if (!dispatch_next()) break;
            // nothing left to run: jump the idle CPU to this arrival
            if (cpu_clock < arr) cpu_clock = arr;
            free_slot = -1;
            for (int i = 0; i < DEFAULT_READY_DEPTH; i++) begin
                if (!occupied[i]) begin
                    free_slot = i;
                    break;
                end
            end
            if (free_slot < 0) begin
                d          = '0;
                d.sched_id = id;
                d.dropped  = 1'b1;
                step_out.push_back(d);
            end else begin
                occupied[free_slot]      = 1'b1;
                slots[free_slot].job     = id;
                slots[free_slot].arrival = arr;
                slots[free_slot].length  = len;
                slots[free_slot].prio    = prio;
                slots[free_slot].stamp   = insert_count;
                insert_count++;
            end
            if (last)
                while (dispatch_next());
            if (step_out.size() > 0) step_out[step_out.size()-1].run_last = 1'b1;
            foreach (step_out[i]) pending.push_back(step_out[i]);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 50) $display("MISMATCH: %s", msg);
        endtask

        task compare_field(string name, bit [ID_W-1:0] id, bit [TIME_W-1:0] got_v,
                           bit [TIME_W-1:0] want_v);
            if (got_v != want_v)
                report($sformatf("job %0h %s: got %0h, want %0h", id, name, got_v, want_v));
        endtask

        task check_dispatch(t_dispatch got);
            t_dispatch want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result for job %0h", got.sched_id));
                return;
            end
            want = pending.pop_front();
            compare_field("sched_id", want.sched_id, TIME_W'(got.sched_id),
                          TIME_W'(want.sched_id));
            compare_field("start_time", want.sched_id, got.start_time, want.start_time);
            compare_field("end_time", want.sched_id, got.end_time, want.end_time);
            compare_field("wait_time", want.sched_id, got.wait_time, want.wait_time);
            compare_field("idle_gap", want.sched_id, got.idle_gap, want.idle_gap);
            compare_field("dropped", want.sched_id, TIME_W'(got.dropped),
                          TIME_W'(want.dropped));
            compare_field("run_last", want.sched_id, TIME_W'(got.run_last),
                          TIME_W'(want.run_last));
        endtask

    endclass

endpackage

[tb/tb.sv]
// Testbench top: drives job records with random pacing and checks every dispatch.
`timescale 1ns / 1ps

module tb;

    localparam int ID_W          = nps_pkg::ID_W;
    localparam int TIME_W        = nps_pkg::TIME_W;
    localparam int LEN_W         = nps_pkg::LEN_W;
    localparam int PRIO_W        = nps_pkg::PRIO_W;

    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 21;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [ID_W-1:0]     i_job_id = '0;
    logic [TIME_W-1:0]   i_arrival_time = '0;
    logic [LEN_W-1:0]    i_run_length = '0;
    logic [PRIO_W-1:0]   i_job_priority = '0;
    logic                i_is_final_job = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [ID_W-1:0]     o_sched_id;
    logic [TIME_W-1:0]   o_start_time;
    logic [TIME_W-1:0]   o_end_time;
    logic [TIME_W-1:0]   o_wait_time;
    logic [TIME_W-1:0]   o_idle_gap;
    logic                o_dropped;
    logic                o_run_last;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_order_descending = 1'b0;

    nps_tb_pkg::dispatch_tracker tracker = new();
    int                  quiet_cycles = 0;
    int                  burst_left = 0;
    bit                  hold_req = 1'b0;
    bit [TIME_W-1:0]     arrival_base = 32'h0004_0000;
    int                  phase_style [PHASES] = '{0, 3, 1, 2, 0, 3, 2};

    nonpreemptive_priority_scheduler_top i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_job_id               (i_job_id),
        .i_arrival_time         (i_arrival_time),
        .i_run_length           (i_run_length),
        .i_job_priority         (i_job_priority),
        .i_is_final_job         (i_is_final_job),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_sched_id             (o_sched_id),
        .o_start_time           (o_start_time),
        .o_end_time             (o_end_time),
        .o_wait_time            (o_wait_time),
        .o_idle_gap             (o_idle_gap),
        .o_dropped              (o_dropped),
        .o_run_last             (o_run_last),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_order_descending (i_cfg_order_descending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sample every transfer at the rising edge; watch for a hung handshake.
    always @(posedge i_clk) begin
        bit moved;
        nps_tb_pkg::t_dispatch got;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.order_desc = i_cfg_order_descending;
                moved = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                tracker.note_job(i_job_id, i_arrival_time, i_run_length, i_job_priority,
                                 i_is_final_job);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                got.sched_id   = o_sched_id;
                got.start_time = o_start_time;
                got.end_time   = o_end_time;
                got.wait_time  = o_wait_time;
                got.idle_gap   = o_idle_gap;
                got.dropped    = o_dropped;
                got.run_last   = o_run_last;
                tracker.check_dispatch(got);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("nonpreemptive_priority_scheduler_top verification failed");
                $finish;
            end
        end
    end

    // Receiver: stall in patterns that change now and then, plus one long hold-off.
    initial begin
        int hold_left;
        int mode;
        int mode_left;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (mode)
                    0: i_out_stall = 1'b0;
                    1: i_out_stall = ($urandom_range(0, 3) == 0);
                    2: i_out_stall = ($urandom_range(0, 1) == 1);
                    default: i_out_stall = (mode_left % 4 != 0);
                endcase
            end
        end
    end

    task automatic send_job(bit [ID_W-1:0] id, bit [TIME_W-1:0] arr, bit [LEN_W-1:0] len,
                            bit [PRIO_W-1:0] prio, bit last);
        @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_job_id       = id;
        i_arrival_time = arr;
        i_run_length   = len;
        i_job_priority = prio;
        i_is_final_job = last;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Insert a random gap between bursts of back-to-back transfers.
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        burst_left--;
    endtask

    task automatic write_order(bit desc);
        @(negedge i_clk);
        i_cfg_valid            = 1'b1;
        i_cfg_order_descending = desc;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(int style);
        bit [TIME_W-1:0] arr;
        bit [LEN_W-1:0]  len;
        bit [PRIO_W-1:0] prio;
        bit              last;
        int              pick;
        case (style)
            1: arrival_base = 32'hFFFF_FF00 | $urandom_range(0, 255);
            2: arrival_base = $urandom();
            default: ;
        endcase
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (style == 3 && pick < 60) begin
                arr = arrival_base;
            end else if (pick < 10) begin
                // out of order: earlier than the running base
                arr = arrival_base - $urandom_range(1, 200);
            end else if (pick < 20) begin
                arrival_base += $urandom_range(1000, 70000);
                arr = arrival_base;
            end else begin
                arrival_base += $urandom_range(0, 40);
                arr = arrival_base;
            end
            pick = $urandom_range(0, 19);
            len  = (pick == 0) ? '0
                 : LEN_W'((pick == 1) ? $urandom_range(0, 65535) : $urandom_range(1, 40));
            prio = PRIO_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                : $urandom_range(0, 255));
            last = (k == PHASE_ITEMS - 1) ? ($urandom_range(0, 1) == 1)
                                          : ($urandom_range(0, 24) == 0);
            pace();
            send_job(ID_W'($urandom_range(0, 65535)), arr, len, prio, last);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_order(nps_pkg::ORDER_ASC);
        // first job, field extremes, priority tie, out-of-order arrival, idle jump
        send_job(16'h0000, 32'd0, 16'd0, 8'h80, 1'b0);
        send_job(16'hFFFF, 32'd0, 16'hFFFF, 8'hFF, 1'b0);
        send_job(16'd1, 32'd0, 16'd5, 8'h00, 1'b0);
        send_job(16'd2, 32'd0, 16'd3, 8'h00, 1'b0);
        send_job(16'd3, 32'd10, 16'd7, 8'h10, 1'b0);
        send_job(16'd4, 32'd5, 16'd2, 8'h20, 1'b0);
        send_job(16'd5, 32'h0002_0000, 16'd1, 8'h05, 1'b1);
        // fill the table at one arrival; the final job overflows and drains it
        for (int k = 0; k < nps_pkg::DEFAULT_READY_DEPTH + 1; k++)
            send_job(ID_W'(16'h0100 + k), 32'h0003_0000, LEN_W'($urandom_range(0, 20)),
                     PRIO_W'($urandom_range(0, 3)), k == nps_pkg::DEFAULT_READY_DEPTH);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0)
                write_order(nps_pkg::ORDER_DESC);
            else if (p == 1)
                write_order(nps_pkg::ORDER_ASC);
            else
                write_order($urandom_range(0, 1) ? nps_pkg::ORDER_DESC : nps_pkg::ORDER_ASC);
            if (p == 2) hold_req = 1'b1;
            run_phase(phase_style[p]);
            wait_idle();
        end

        if (tracker.mismatches == 0)
            $display("nonpreemptive_priority_scheduler_top verification clean");
        else
            $display("nonpreemptive_priority_scheduler_top verification failed");
        $finish;
    end

endmodule

[sim.f]
design/nps_pkg.sv
design/nps_ctrl.sv
design/nps_dp.sv
design/nonpreemptive_priority_scheduler_top.sv
tb/nps_tb_pkg.sv
tb/tb.sv
